// ----- hdl/bve_pkg.sv -----
`default_nettype none
package bve_pkg;

    // Fixed field widths.
    localparam int POS_W  = 5;
    localparam int SIZE_W = 6;
    localparam int ORG_W  = 2;
    localparam int MASK_W = 27;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 27;
    // Window counters cover the largest window of 3.
    localparam int WIN_IW = 2;
    localparam int PT_W   = 5;
    // Neighbor coordinate, two's complement, range -2 to 34.
    localparam int CRD_W  = 8;

    typedef enum logic [CFG_AW-1:0] {
        CFG_SIZE_X   = 3'd0,
        CFG_SIZE_Y   = 3'd1,
        CFG_SIZE_Z   = 3'd2,
        CFG_MASK     = 3'd3,
        CFG_ORIGIN_X = 3'd4,
        CFG_ORIGIN_Y = 3'd5,
        CFG_ORIGIN_Z = 3'd6
    } t_cfg_idx;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
    } t_pos;

    typedef struct packed {
        logic [ORG_W-1:0] x;
        logic [ORG_W-1:0] y;
        logic [ORG_W-1:0] z;
    } t_org;

    typedef struct packed {
        logic [SIZE_W-1:0] x;
        logic [SIZE_W-1:0] y;
        logic [SIZE_W-1:0] z;
    } t_size;

    typedef struct packed {
        logic [WIN_IW-1:0] i;
        logic [WIN_IW-1:0] j;
        logic [WIN_IW-1:0] s;
    } t_win;

    typedef struct packed {
        logic in_store;
        logic in_vol;
    } t_chk;

endpackage
`default_nettype wire

// ----- hdl/bve_addr.sv -----
`default_nettype none
module bve_addr
    import bve_pkg::*;
#(
    parameter int MAX_X = 32,
    parameter int MAX_Y = 32,
    parameter int MAX_Z = 32,
    parameter int AW    = 15
) (
    input  wire t_pos          i_base,
    input  wire t_org          i_org,
    input  wire t_win          i_win,
    input  wire t_size         i_size,
    output t_chk               o_chk,
    output logic [AW-1:0]      o_addr
);

    logic [CRD_W-1:0] cx, cy, cz;
    logic [8:0]       sx, sy, sz;
    logic             ok_x, ok_y, ok_z;
    logic             st_x, st_y, st_z;

    // Neighbor coordinate is base + origin - window index; the top bit is the sign.
    assign cx = {3'b000, i_base.x} + {6'b0, i_org.x} - {6'b0, i_win.i};
    assign cy = {3'b000, i_base.y} + {6'b0, i_org.y} - {6'b0, i_win.j};
    assign cz = {3'b000, i_base.z} + {6'b0, i_org.z} - {6'b0, i_win.s};

    // Configured sizes saturate at the store dimensions.
    assign sx = ({3'b000, i_size.x} > 9'(MAX_X)) ? 9'(MAX_X) : {3'b000, i_size.x};
    assign sy = ({3'b000, i_size.y} > 9'(MAX_Y)) ? 9'(MAX_Y) : {3'b000, i_size.y};
    assign sz = ({3'b000, i_size.z} > 9'(MAX_Z)) ? 9'(MAX_Z) : {3'b000, i_size.z};

    assign st_x = !cx[CRD_W-1] && ({1'b0, cx} < 9'(MAX_X));
    assign st_y = !cy[CRD_W-1] && ({1'b0, cy} < 9'(MAX_Y));
    assign st_z = !cz[CRD_W-1] && ({1'b0, cz} < 9'(MAX_Z));
    assign ok_x = !cx[CRD_W-1] && ({1'b0, cx} < sx);
    assign ok_y = !cy[CRD_W-1] && ({1'b0, cy} < sy);
    assign ok_z = !cz[CRD_W-1] && ({1'b0, cz} < sz);

    assign o_chk.in_store = st_x && st_y && st_z;
    assign o_chk.in_vol   = ok_x && ok_y && ok_z;

    // Only meaningful when the coordinate lies inside the store.
    assign o_addr = AW'(((32'(cz[CRD_W-2:0]) * MAX_Y + 32'(cy[CRD_W-2:0])) * MAX_X)
                        + 32'(cx[CRD_W-2:0]));

endmodule
`default_nettype wire

// ----- hdl/bve_mem.sv -----
`default_nettype none
module bve_mem
    import bve_pkg::*;
#(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  wire            i_clk,
    input  wire            i_we,
    input  wire [AW-1:0]   i_addr,
    input  wire            i_wdata,
    output logic           o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- hdl/binary_volume_erosion.sv -----
`default_nettype none
// Binary volume erosion with a structuring element of up to 3x3x3.
//
// Items enter on start while busy is low. An item with opcode write stores
// i_voxel_bit at (i_pos_x, i_pos_y, i_pos_z); a position beyond the store
// is dropped, and busy stays low. An item with opcode query raises busy
// through the scan and drain states: in the scan the sequencer walks the
// window one point a cycle through one shared coordinate and address unit,
// issuing one read per cycle to the single-port volume memory, and the drain
// state folds in the last read. The result then appears on o_eroded_bit with
// o_valid high for exactly one cycle; the receiver cannot stall, and a new
// item may be started in that same cycle.
//
// Configuration is written by the user through i_cfg_we, i_cfg_addr, i_cfg_data
// while the block is idle; the block does not enforce it. Reset sets the sizes to
// 32, the element to all ones and the origin to 1 on each axis. The volume memory
// is not cleared: every voxel that a query reaches must have been written first.
module binary_volume_erosion
    import bve_pkg::*;
#(
    parameter int MAX_X  = 32,
    parameter int MAX_Y  = 32,
    parameter int MAX_Z  = 32,
    parameter int WINDOW = 3
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire                i_opcode,
    input  wire [POS_W-1:0]    i_pos_x,
    input  wire [POS_W-1:0]    i_pos_y,
    input  wire [POS_W-1:0]    i_pos_z,
    input  wire                i_voxel_bit,
    output logic               o_valid,
    output logic               o_eroded_bit,
    input  wire                i_cfg_we,
    input  wire [CFG_AW-1:0]   i_cfg_addr,
    input  wire [CFG_DW-1:0]   i_cfg_data
);

    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTS   = WINDOW * WINDOW * WINDOW;

    t_state            r_state, n_state;
    t_size             r_size;
    t_org              r_org;
    logic [MASK_W-1:0] r_mask;
    t_pos              r_pos;
    t_win              r_win, n_win;
    logic [PT_W-1:0]   r_k;
    logic              r_pend, n_pend;
    logic              r_res, n_res;
    logic              r_valid;
    logic              r_out;

    t_pos              au_base;
    t_org              au_org;
    t_win              au_win;
    t_chk              au_chk;
    logic [AW-1:0]     au_addr;
    logic              mem_we;
    logic              mem_rdata;
    logic              accept;
    logic              sel;
    logic              last;
    logic              res_in;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);
    assign last   = (r_k == PT_W'(PTS - 1));
    assign sel    = r_mask[r_k];

    bve_addr #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z),
        .AW    (AW)
    ) u_addr (
        .i_base (au_base),
        .i_org  (au_org),
        .i_win  (au_win),
        .i_size (r_size),
        .o_chk  (au_chk),
        .o_addr (au_addr)
    );

    bve_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (au_addr),
        .i_wdata (i_voxel_bit),
        .o_rdata (mem_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_opcode == OP_QUERY) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath control.
    always_comb begin
        au_base = '{x: i_pos_x, y: i_pos_y, z: i_pos_z};
        au_org  = '0;
        au_win  = '0;
        mem_we  = 1'b0;
        n_win   = r_win;
        n_pend  = 1'b0;
        // A read issued last cycle is folded in now.
        res_in  = r_res && !(r_pend && !mem_rdata);
        n_res   = res_in;
        unique case (r_state)
            ST_IDLE: begin
                mem_we = accept && (i_opcode == OP_WRITE) && au_chk.in_store;
                n_win  = '0;
                n_res  = 1'b1;
            end
            ST_SCAN: begin
                au_base = r_pos;
                au_org  = r_org;
                au_win  = r_win;
                if (sel && !au_chk.in_vol) begin
                    n_res = 1'b0;
                end
                n_pend = sel && au_chk.in_vol;
                n_win.j = r_win.j + 1'b1;
                if (r_win.j == WIN_IW'(WINDOW - 1)) begin
                    n_win.j = '0;
                    n_win.i = r_win.i + 1'b1;
                    if (r_win.i == WIN_IW'(WINDOW - 1)) begin
                        n_win.i = '0;
                        n_win.s = r_win.s + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                n_win = '0;
            end
            default: n_win = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_size    <= '{x: 6'd32, y: 6'd32, z: 6'd32};
            r_org     <= '{x: 2'd1, y: 2'd1, z: 2'd1};
            r_mask    <= '1;
            r_win     <= '0;
            r_k       <= '0;
            r_pend    <= 1'b0;
            r_res     <= 1'b1;
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_win   <= n_win;
            r_pend  <= n_pend;
            r_res   <= n_res;
            r_valid <= (r_state == ST_DRAIN);
            r_k     <= (r_state == ST_SCAN) ? r_k + 1'b1 : '0;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_SIZE_X:   r_size.x <= i_cfg_data[SIZE_W-1:0];
                    CFG_SIZE_Y:   r_size.y <= i_cfg_data[SIZE_W-1:0];
                    CFG_SIZE_Z:   r_size.z <= i_cfg_data[SIZE_W-1:0];
                    CFG_MASK:     r_mask   <= i_cfg_data[MASK_W-1:0];
                    CFG_ORIGIN_X: r_org.x  <= i_cfg_data[ORG_W-1:0];
                    CFG_ORIGIN_Y: r_org.y  <= i_cfg_data[ORG_W-1:0];
                    CFG_ORIGIN_Z: r_org.z  <= i_cfg_data[ORG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos <= '{x: i_pos_x, y: i_pos_y, z: i_pos_z};
        end
        if (r_state == ST_DRAIN) begin
            r_out <= res_in;
        end
    end

    assign o_valid      = r_valid;
    assign o_eroded_bit = r_out;

    a_valid_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_DRAIN))
        else $error("result strobe without a finished scan");

    a_query_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == OP_QUERY) |=> (busy && r_k == '0))
        else $error("accepted query did not start a scan");

    a_no_pending_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend)
        else $error("memory read pending while idle");

    a_scan_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (32'(r_k) < PTS))
        else $error("window point counter overran");

endmodule
`default_nettype wire

// ----- tb/binary_volume_erosion_tb.sv -----
`timescale 1ns / 100ps
module binary_volume_erosion_tb;
    import bve_pkg::*;

    localparam int EDGE        = 32;
    localparam int WIN         = 3;
    localparam int ITEM_TARGET = 1600;
    localparam int STALL_LIMIT = 1000;
    localparam int CENTER_PT   = 13;
    localparam logic [CFG_AW-1:0] CFG_SPARE = 3'd7;
    localparam logic [MASK_W-1:0] MASK_FULL = '1;

    typedef struct packed {
        logic op;
        t_pos pos;
        logic voxel;
    } t_item;

    // Mirror of the volume and the registers; predicts the eroded bit of each query.
    class erosion_board;
        bit                voxels[EDGE*EDGE*EDGE];
        bit                loaded[EDGE*EDGE*EDGE];
        t_size             vol_size;
        t_org              org;
        logic [MASK_W-1:0] elem;
        bit                pending_erosions[$];
        int                errors;
        int                queries;
        int                ones;

        function new();
            vol_size.x = 6'd32;
            vol_size.y = 6'd32;
            vol_size.z = 6'd32;
            org.x = 2'd1;
            org.y = 2'd1;
            org.z = 2'd1;
            elem = MASK_FULL;
        endfunction

        function int addr_of(int x, int y, int z);
            return (z * EDGE + y) * EDGE + x;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
            case (idx)
                CFG_SIZE_X:   vol_size.x = data[SIZE_W-1:0];
                CFG_SIZE_Y:   vol_size.y = data[SIZE_W-1:0];
                CFG_SIZE_Z:   vol_size.z = data[SIZE_W-1:0];
                CFG_MASK:     elem = data[MASK_W-1:0];
                CFG_ORIGIN_X: org.x = data[ORG_W-1:0];
                CFG_ORIGIN_Y: org.y = data[ORG_W-1:0];
                CFG_ORIGIN_Z: org.z = data[ORG_W-1:0];
                default: ;
            endcase
        endfunction

        function void neighbor(t_pos p, int s, int i, int j, output int nx, ny, nz);
            nx = int'(p.x) + int'(org.x) - i;
            ny = int'(p.y) + int'(org.y) - j;
            nz = int'(p.z) + int'(org.z) - s;
        endfunction

        function bit eroded_at(t_pos p);
            int lx, ly, lz, nx, ny, nz;
            bit r;
            lx = (vol_size.x > EDGE) ? EDGE : vol_size.x;
            ly = (vol_size.y > EDGE) ? EDGE : vol_size.y;
            lz = (vol_size.z > EDGE) ? EDGE : vol_size.z;
            r = 1'b1;
            for (int s = 0; s < WIN; s++) begin
                for (int i = 0; i < WIN; i++) begin
                    for (int j = 0; j < WIN; j++) begin
                        if (elem[s*WIN*WIN + i*WIN + j]) begin
                            neighbor(p, s, i, j, nx, ny, nz);
                            if (nx < 0 || ny < 0 || nz < 0 || nx >= lx || ny >= ly || nz >= lz)
                                r = 1'b0;
                            else if (!voxels[addr_of(nx, ny, nz)])
                                r = 1'b0;
                        end
                    end
                end
            end
            return r;
        endfunction

        function void note_item(t_item it);
            int a;
            bit want;
            a = addr_of(it.pos.x, it.pos.y, it.pos.z);
            if (it.op == OP_WRITE) begin
                voxels[a] = it.voxel;
                loaded[a] = 1'b1;
            end else begin
                want = eroded_at(it.pos);
                pending_erosions.push_back(want);
                queries++;
                ones += want;
            end
        endfunction

        function void check_result(logic got);
            bit want;
            if (pending_erosions.size() == 0) begin
                $error("eroded_bit: expected no result, actual %b", got);
                errors++;
            end else begin
                want = pending_erosions.pop_front();
                if (got !== want) begin
                    $error("eroded_bit: expected %b, actual %b", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_opcode = OP_WRITE;
    logic [POS_W-1:0]  i_pos_x = '0;
    logic [POS_W-1:0]  i_pos_y = '0;
    logic [POS_W-1:0]  i_pos_z = '0;
    logic              i_voxel_bit = 1'b0;
    logic              o_valid;
    logic              o_eroded_bit;
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = CFG_SIZE_X;
    logic [CFG_DW-1:0] i_cfg_data = '0;

    erosion_board board;
    bit           start_up;
    bit           quiet;
    int           density = 100;
    int           items_sent;
    int           phases;
    int           stall_cycles = 0;
    t_pos         span_lo, span_hi;

    binary_volume_erosion dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_voxel_bit  (i_voxel_bit),
        .o_valid      (o_valid),
        .o_eroded_bit (o_eroded_bit),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            board.check_result(o_eroded_bit);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("binary_volume_erosion test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_pos pos_at(int x, int y, int z);
        t_pos p;
        p.x = POS_W'(x);
        p.y = POS_W'(y);
        p.z = POS_W'(z);
        return p;
    endfunction

    function automatic logic draw_voxel();
        return $urandom_range(0, 99) < density;
    endfunction

    // Mostly small volumes, with the extremes and out-of-range sizes now and then.
    function automatic logic [SIZE_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return SIZE_W'($urandom_range(1, 8));
        if (roll < 65) return SIZE_W'(32);
        if (roll < 70) return '0;
        if (roll < 75) return SIZE_W'($urandom_range(33, 63));
        return SIZE_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [MASK_W-1:0] pick_mask();
        case ($urandom_range(0, 4))
            0: return MASK_FULL;
            1: return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
            2: return MASK_W'($urandom & $urandom & $urandom);
            3: return MASK_W'($urandom);
            default: return ($urandom_range(0, 2) == 0) ? '0 : MASK_FULL;
        endcase
    endfunction

    // Upper data bits beyond the register width carry junk.
    function automatic logic [CFG_DW-1:0] with_noise(logic [CFG_DW-1:0] v, int w);
        logic [CFG_DW-1:0] keep;
        keep = (CFG_DW'(1) << w) - 1;
        return (CFG_DW'($urandom) & ~keep) | (v & keep);
    endfunction

    // Small volumes are queried across and just past their whole extent; large ones
    // in a small window so that the neighborhoods fill up quickly.
    function automatic void axis_span(logic [SIZE_W-1:0] v, output logic [POS_W-1:0] lo, hi);
        int lim, base;
        lim = (v > EDGE) ? EDGE : v;
        if (lim <= 8) begin
            lo = '0;
            hi = POS_W'(lim + 1);
        end else begin
            base = $urandom_range(0, EDGE - 1);
            lo = POS_W'(base);
            hi = POS_W'((base + 5 > EDGE - 1) ? EDGE - 1 : base + 5);
        end
    endfunction

    function automatic t_pos pos_in_span();
        return pos_at($urandom_range(span_lo.x, span_hi.x),
                      $urandom_range(span_lo.y, span_hi.y),
                      $urandom_range(span_lo.z, span_hi.z));
    endfunction

    task automatic drop_start();
        if (start_up) begin
            start <= 1'b0;
            start_up = 1'b0;
        end
    endtask

    task automatic send_item(t_item it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            drop_start();
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        start_up     = 1'b1;
        i_opcode    <= it.op;
        i_pos_x     <= it.pos.x;
        i_pos_y     <= it.pos.y;
        i_pos_z     <= it.pos.z;
        i_voxel_bit <= it.voxel;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_item(it);
        items_sent++;
    endtask

    task automatic send_write(int x, int y, int z, logic v);
        t_item it;
        it.op = OP_WRITE;
        it.pos = pos_at(x, y, z);
        it.voxel = v;
        send_item(it);
    endtask

    // Every neighbor the element selects inside the store is loaded before the query.
    task automatic send_query(t_pos p);
        t_item it;
        int nx, ny, nz;
        for (int s = 0; s < WIN; s++) begin
            for (int i = 0; i < WIN; i++) begin
                for (int j = 0; j < WIN; j++) begin
                    if (board.elem[s*WIN*WIN + i*WIN + j]) begin
                        board.neighbor(p, s, i, j, nx, ny, nz);
                        if (nx >= 0 && ny >= 0 && nz >= 0 && nx < EDGE && ny < EDGE
                                && nz < EDGE && !board.loaded[board.addr_of(nx, ny, nz)])
                            send_write(nx, ny, nz, draw_voxel());
                    end
                end
            end
        end
        it.op = OP_QUERY;
        it.pos = p;
        it.voxel = $urandom_range(0, 1);
        send_item(it);
    endtask

    task automatic settle();
        drop_start();
        while (board.pending_erosions.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data, bit last);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.set_reg(idx, data);
        if (last) begin
            i_cfg_we <= 1'b0;
        end
    endtask

    task automatic apply_setting(t_size sz, t_org og, logic [MASK_W-1:0] m);
        cfg_write(CFG_SIZE_X, with_noise(CFG_DW'(sz.x), SIZE_W), 1'b0);
        cfg_write(CFG_SIZE_Y, with_noise(CFG_DW'(sz.y), SIZE_W), 1'b0);
        cfg_write(CFG_SIZE_Z, with_noise(CFG_DW'(sz.z), SIZE_W), 1'b0);
        cfg_write(CFG_MASK, CFG_DW'(m), 1'b0);
        cfg_write(CFG_ORIGIN_X, with_noise(CFG_DW'(og.x), ORG_W), 1'b0);
        cfg_write(CFG_ORIGIN_Y, with_noise(CFG_DW'(og.y), ORG_W), 1'b0);
        cfg_write(CFG_ORIGIN_Z, with_noise(CFG_DW'(og.z), ORG_W), 1'b0);
        cfg_write(CFG_SPARE, CFG_DW'($urandom), 1'b1);
        phases++;
    endtask

    initial begin
        t_size sz;
        t_org  og;
        int    roll;

        board = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: a block of ones in the low corner, then the far corner.
        for (int z = 0; z < 2; z++) begin
            for (int y = 0; y < 2; y++) begin
                for (int x = 0; x < 2; x++) begin
                    send_write(x, y, z, 1'b1);
                end
            end
        end
        send_write(EDGE - 1, EDGE - 1, EDGE - 1, 1'b0);
        send_write(EDGE - 2, EDGE - 1, EDGE - 1, 1'b1);
        // The full element reaches outside the volume here.
        send_query(pos_at(0, 0, 0));

        settle();
        cfg_write(CFG_MASK, CFG_DW'(1) << CENTER_PT, 1'b1);
        send_query(pos_at(0, 0, 0));
        send_query(pos_at(1, 1, 1));

        // A zero size leaves nothing inside, while an empty element always passes.
        settle();
        cfg_write(CFG_SIZE_X, '0, 1'b1);
        send_query(pos_at(0, 0, 0));
        settle();
        cfg_write(CFG_MASK, '0, 1'b1);
        send_query(pos_at(0, 0, 0));

        // Oversized extents saturate; an origin of 3 pushes the far corner out.
        settle();
        sz.x = '1;
        sz.y = '1;
        sz.z = '1;
        og.x = 2'd3;
        og.y = 2'd3;
        og.z = 2'd3;
        apply_setting(sz, og, MASK_W'(1));
        send_query(pos_at(EDGE - 1, EDGE - 1, EDGE - 1));
        send_query(pos_at(0, 0, 0));

        while (items_sent < ITEM_TARGET) begin
            settle();
            sz.x = pick_size();
            sz.y = pick_size();
            sz.z = pick_size();
            og.x = $urandom_range(0, 3);
            og.y = $urandom_range(0, 3);
            og.z = $urandom_range(0, 3);
            apply_setting(sz, og, pick_mask());
            quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: density = 50;
                1: density = 85;
                2: density = 97;
                default: density = 100;
            endcase
            axis_span(sz.x, span_lo.x, span_hi.x);
            axis_span(sz.y, span_lo.y, span_hi.y);
            axis_span(sz.z, span_lo.z, span_hi.z);
            repeat ($urandom_range(30, 70)) begin
                if (items_sent >= ITEM_TARGET) break;
                roll = $urandom_range(0, 99);
                if (roll < 15) begin
                    send_write($urandom_range(0, EDGE - 1), $urandom_range(0, EDGE - 1),
                               $urandom_range(0, EDGE - 1), $urandom_range(0, 1));
                end else if (roll < 30) begin
                    send_write($urandom_range(span_lo.x, span_hi.x),
                               $urandom_range(span_lo.y, span_hi.y),
                               $urandom_range(span_lo.z, span_hi.z), draw_voxel());
                end else begin
                    send_query(pos_in_span());
                end
            end
        end

        drop_start();
        while (board.pending_erosions.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (board.pending_erosions.size() != 0) begin
            $error("eroded_bit: expected %0d more results, actual none",
                   board.pending_erosions.size());
            board.errors++;
        end
        $display("Sent %0d items across %0d register settings.", items_sent, phases);
        $display("Checked %0d queries, %0d of which eroded to one.", board.queries, board.ones);
        if (board.errors == 0) begin
            $display("binary_volume_erosion test passed");
        end else begin
            $display("binary_volume_erosion test failed");
        end
        $finish;
    end

endmodule

// ----- binary_volume_erosion.f -----
hdl/bve_pkg.sv
hdl/bve_addr.sv
hdl/bve_mem.sv
hdl/binary_volume_erosion.sv
tb/binary_volume_erosion_tb.sv
